[hdl/page_table_map_unmap_engine_top_defines.svh]
// Assertion macros for the page table map/unmap engine.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef PAGE_TABLE_MAP_UNMAP_ENGINE_TOP_DEFINES_SVH
`define PAGE_TABLE_MAP_UNMAP_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PTME_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptme assertion failed");
`define PTME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptme assertion failed");
`else
`define PTME_ASSERT_SAME(label, ante, cons)
`define PTME_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/ptme_pkg.sv]
// Shared constants, types and helpers for the page table map/unmap engine.
// No dependencies; every module in the project imports it.
package ptme_pkg;

    localparam int TABLE_PAGES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLICE_W           = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W            = $clog2(TABLE_PAGES);
    localparam int FREE_W            = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W            = PAGE_W + SLICE_W;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;

    localparam int VPN_W   = 44;
    localparam int FRAME_W = 40;
    localparam int PERM_W  = 3;
    localparam int PTE_W   = 64;
    localparam int LVL_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    localparam int PTE_FRAME_LO = 12;
    localparam int PTE_FRAME_HI = PTE_FRAME_LO + FRAME_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b1;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_UNMAP = 1'b1;

    localparam int PERM_WRITE = 0;
    localparam int PERM_EXEC  = 1;
    localparam int PERM_USER  = 2;

    localparam logic [LVL_W-1:0] LVL_LEAF  = 3'd1;
    localparam logic [LVL_W-1:0] LVL_ABOVE = 3'd2;
    localparam logic [LVL_W-1:0] LVL_FOUR  = 3'd4;
    localparam logic [LVL_W-1:0] LVL_FIVE  = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FILL,
        ST_LINK,
        ST_LEAF,
        ST_ZAP
    } state_t;

    typedef struct packed {
        logic               five_level;
        logic [FRAME_W-1:0] table_base;
    } cfg_t;

    typedef struct packed {
        logic               sub;
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] sum;
        logic               in_pool;
    } alu_rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PTE_W-1:0]  wdata;
    } store_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               ok;
        logic [FRAME_W-1:0] old_frame;
    } ctrl_status_t;

    function automatic logic [SLICE_W-1:0] slice_idx(input logic [VPN_W-1:0] vpn,
                                                    input logic [LVL_W-1:0] lvl);
        logic [SLICE_W-1:0] idx;
        case (lvl)
            3'd1:    idx = vpn[8:0];
            3'd2:    idx = vpn[17:9];
            3'd3:    idx = vpn[26:18];
            3'd4:    idx = vpn[35:27];
            3'd5:    idx = {1'b0, vpn[43:36]};
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage

[hdl/ptme_store.sv]
// Table store: single-port RAM holding every pool page, registered read.
// Depends on ptme_pkg.
module ptme_store (
    input  logic                      clk,
    input  ptme_pkg::store_req_t      req,
    output logic [ptme_pkg::PTE_W-1:0] rdata
);
    import ptme_pkg::*;

    logic [PTE_W-1:0] mem [STORE_DEPTH];
    logic [PTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ptme_alu.sv]
// Shared frame adder: link frame build and pool offset with range check.
// Depends on ptme_pkg.
module ptme_alu (
    input  ptme_pkg::alu_req_t req,
    output ptme_pkg::alu_rsp_t rsp
);
    import ptme_pkg::*;

    localparam logic [FRAME_W-1:0] POOL_LIMIT = FRAME_W'(TABLE_PAGES);

    logic [FRAME_W-1:0] sum;

    always_comb
    begin
        if (req.sub)
        begin
            sum = req.a - req.b;
        end
        else
        begin
            sum = req.a + req.b;
        end
        rsp.sum     = sum;
        rsp.in_pool = (sum < POOL_LIMIT);
    end

endmodule

[hdl/ptme_ctrl.sv]
// Walk sequencer: clearing pass, table walk, allocation, leaf update, result.
// Depends on ptme_pkg; drives ptme_store and ptme_alu.
module ptme_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptme_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic                          cmd,
    input  logic [ptme_pkg::VPN_W-1:0]    vpn,
    input  logic [ptme_pkg::FRAME_W-1:0]  frame,
    input  logic [ptme_pkg::PERM_W-1:0]   perms,
    output ptme_pkg::store_req_t          store_req,
    input  logic [ptme_pkg::PTE_W-1:0]    store_rdata,
    output ptme_pkg::alu_req_t            alu_req,
    input  ptme_pkg::alu_rsp_t            alu_rsp,
    output ptme_pkg::ctrl_status_t        status
);
    import ptme_pkg::*;

    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [FREE_W:0]   FREE_LIMIT = (FREE_W + 1)'(TABLE_PAGES);

    state_t               state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [VPN_W-1:0]     vpn_reg, vpn_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [PERM_W-1:0]    perms_reg, perms_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic                 grow_reg, grow_next;
    logic [SLICE_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]    sweep_reg, sweep_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic                 done_reg, done_next;
    logic                 ok_reg, ok_next;
    logic [FRAME_W-1:0]   old_frame_reg, old_frame_next;

    logic [ADDR_W-1:0]    slot_addr;
    logic [PAGE_W-1:0]    new_page;
    logic                 entry_zero;
    logic [FREE_W:0]      need_sum;
    logic [LVL_W-1:0]     lvl_down;
    logic [PTE_W-1:0]     leaf_pte;

    assign slot_addr  = {page_reg, slice_idx(vpn_reg, lvl_reg)};
    assign new_page   = free_reg[PAGE_W-1:0];
    assign entry_zero = (store_rdata == '0);
    assign lvl_down   = lvl_reg - 3'd1;
    assign need_sum   = {1'b0, free_reg} + (FREE_W + 1)'(lvl_down);
    assign leaf_pte   = {~perms_reg[PERM_EXEC], 11'b0, frame_reg, 9'b0,
                         perms_reg[PERM_USER], perms_reg[PERM_WRITE], 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            fill_reg  <= '0;
            free_reg  <= FREE_W'(1);
            grow_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            fill_reg  <= fill_next;
            free_reg  <= free_next;
            grow_reg  <= grow_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        vpn_reg       <= vpn_next;
        frame_reg     <= frame_next;
        perms_reg     <= perms_next;
        lvl_reg       <= lvl_next;
        page_reg      <= page_next;
        ok_reg        <= ok_next;
        old_frame_reg <= old_frame_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        vpn_next       = vpn_reg;
        frame_next     = frame_reg;
        perms_next     = perms_reg;
        lvl_next       = lvl_reg;
        page_next      = page_reg;
        grow_next      = grow_reg;
        fill_next      = fill_reg;
        sweep_next     = sweep_reg;
        free_next      = free_reg;
        done_next      = 1'b0;
        ok_next        = ok_reg;
        old_frame_next = old_frame_reg;

        store_req.we    = 1'b0;
        store_req.addr  = slot_addr;
        store_req.wdata = '0;

        alu_req.sub = 1'b1;
        alu_req.a   = store_rdata[PTE_FRAME_HI:PTE_FRAME_LO];
        alu_req.b   = cfg.table_base;

        case (state_reg)
            ST_CLEAR:
            begin
                store_req.we   = 1'b1;
                store_req.addr = sweep_reg;
                sweep_next     = sweep_reg + 1'b1;
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    vpn_next   = vpn;
                    frame_next = frame;
                    perms_next = perms;
                    lvl_next   = cfg.five_level ? LVL_FIVE : LVL_FOUR;
                    page_next  = '0;
                    grow_next  = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (lvl_reg == LVL_LEAF)
                begin
                    old_frame_next = store_rdata[PTE_FRAME_HI:PTE_FRAME_LO];
                    state_next     = ST_ZAP;
                end
                else if (entry_zero && cmd_reg == CMD_UNMAP)
                begin
                    ok_next        = 1'b1;
                    old_frame_next = '0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (entry_zero && !grow_reg && need_sum > FREE_LIMIT)
                begin
                    ok_next        = 1'b0;
                    old_frame_next = '0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (entry_zero)
                begin
                    grow_next  = 1'b1;
                    fill_next  = '0;
                    state_next = ST_FILL;
                end
                else if (!alu_rsp.in_pool && !grow_reg)
                begin
                    ok_next        = (cmd_reg == CMD_UNMAP);
                    old_frame_next = '0;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    // keep the page on a broken link while building
                    if (alu_rsp.in_pool)
                    begin
                        page_next = alu_rsp.sum[PAGE_W-1:0];
                    end
                    lvl_next = lvl_down;
                    if (lvl_reg == LVL_ABOVE && cmd_reg == CMD_MAP)
                    begin
                        state_next = ST_LEAF;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FILL:
            begin
                store_req.we   = 1'b1;
                store_req.addr = {new_page, fill_reg};
                fill_next      = fill_reg + 1'b1;
                if (fill_reg == '1)
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                alu_req.sub     = 1'b0;
                alu_req.a       = cfg.table_base;
                alu_req.b       = FRAME_W'(new_page);
                store_req.we    = 1'b1;
                store_req.wdata = {12'b0, alu_rsp.sum, 9'b0, 3'b111};
                page_next       = new_page;
                free_next       = free_reg + 1'b1;
                lvl_next        = lvl_down;
                if (lvl_reg == LVL_ABOVE)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_LEAF:
            begin
                store_req.we    = 1'b1;
                store_req.wdata = leaf_pte;
                ok_next         = 1'b1;
                old_frame_next  = '0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_ZAP:
            begin
                store_req.we = 1'b1;
                ok_next      = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign status.busy      = (state_reg != ST_IDLE);
    assign status.done      = done_reg;
    assign status.ok        = ok_reg;
    assign status.old_frame = old_frame_reg;

endmodule

[hdl/page_table_map_unmap_engine_top.sv]
// Page table map/unmap engine: configuration registers, sequencer, store, adder.
// Depends on ptme_pkg, ptme_store, ptme_alu, ptme_ctrl and the defines header.
//
// Usage:
//   Requests: drive cmd, vpn, frame and perms with start high; the request is
//   taken at a clock edge where start is high and busy is low. busy stays high
//   until the result has been produced.
//   Results: done is high for exactly one cycle with ok and old_frame valid.
//   The receiver cannot stall; the result is gone after that cycle.
//   Configuration: cfg_we with cfg_index (0 five_level, 1 table_base) and
//   cfg_data, written at any edge with cfg_we high; the user must write only
//   while idle, as the block itself does not enforce it.
//   Walk: each table level is read through the single store port (ST_READ,
//   ST_CHECK); the leaf is written in ST_LEAF or ST_ZAP. A table allocated by
//   a map is cleared one entry a cycle (ST_FILL), then linked (ST_LINK).
//   Throughput: the next request is taken in the cycle that done is high.
//   Reset: the whole store is swept to zero, one entry a cycle, with busy
//   high; configuration writes are taken meanwhile.
module page_table_map_unmap_engine_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [ptme_pkg::VPN_W-1:0]        vpn,
    input  logic [ptme_pkg::FRAME_W-1:0]      frame,
    input  logic [ptme_pkg::PERM_W-1:0]       perms,
    output logic                              done,
    output logic                              ok,
    output logic [ptme_pkg::FRAME_W-1:0]      old_frame,
    input  logic                              cfg_we,
    input  logic [ptme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptme_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ptme_pkg::*;

    `include "page_table_map_unmap_engine_top_defines.svh"

    logic               five_level_reg;
    logic [FRAME_W-1:0] table_base_reg;
    cfg_t               cfg;
    store_req_t         store_req;
    logic [PTE_W-1:0]   store_rdata;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    ctrl_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_level_reg <= 1'b0;
            table_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIVE_LEVEL: five_level_reg <= cfg_data[0];
                CFG_TABLE_BASE: table_base_reg <= cfg_data[FRAME_W-1:0];
                default:        five_level_reg <= five_level_reg;
            endcase
        end
    end

    assign cfg.five_level = five_level_reg;
    assign cfg.table_base = table_base_reg;

    ptme_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (start),
        .cmd         (cmd),
        .vpn         (vpn),
        .frame       (frame),
        .perms       (perms),
        .store_req   (store_req),
        .store_rdata (store_rdata),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp),
        .status      (status)
    );

    ptme_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    ptme_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign busy      = status.busy;
    assign done      = status.done;
    assign ok        = status.ok;
    assign old_frame = status.old_frame;

    `PTME_ASSERT_SAME(a_done_when_idle, status.done, !status.busy)
    `PTME_ASSERT_NEXT(a_busy_after_request, start && !status.busy, status.busy)
    `PTME_ASSERT_SAME(a_fail_no_frame, status.done && !status.ok, status.old_frame == '0)

endmodule

[sim/page_table_map_unmap_engine_top_test.sv]
// Self-checking testbench for the page table map/unmap engine top level.
// Predicts every map and unmap against a private copy of the page table pool.
// Depends on ptme_pkg and page_table_map_unmap_engine_top.
`timescale 1ns / 100ps

module page_table_map_unmap_engine_top_test;

    import ptme_pkg::*;

    localparam logic [FRAME_W-1:0] BASE_WRAP      = 40'hFF_FFFF_FFFD;
    localparam logic [FRAME_W-1:0] FRAME_MAX      = '1;
    localparam int                 WATCHDOG_LIMIT = 200000;
    localparam int                 KNOWN_VPN_MAX  = 96;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] old_frame;
    } page_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [VPN_W-1:0]      vpn;
    logic [FRAME_W-1:0]    frame;
    logic [PERM_W-1:0]     perms;
    logic                  done;
    logic                  ok;
    logic [FRAME_W-1:0]    old_frame;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [PTE_W-1:0]   pt_mem [STORE_DEPTH];
    int                 free_page;
    logic               five_level_walk;
    logic [FRAME_W-1:0] pool_base;

    page_result_t     pending_results[$];
    page_result_t     oldest_result;
    logic [VPN_W-1:0] known_vpns[$];
    int               failures;
    int               idle_cycles;
    bit               idling_on;

    page_table_map_unmap_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .vpn       (vpn),
        .frame     (frame),
        .perms     (perms),
        .done      (done),
        .ok        (ok),
        .old_frame (old_frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int entry_addr(input int page, input logic [VPN_W-1:0] v,
                                      input int lvl);
        logic [SLICE_W-1:0] idx;
        idx = SLICE_W'(v >> (9 * (lvl - 1)));
        return page * ENTRIES_PER_TABLE + int'(idx);
    endfunction

    function automatic int linked_page(input logic [PTE_W-1:0] e);
        logic [FRAME_W-1:0] off;
        off = e[PTE_FRAME_HI:PTE_FRAME_LO] - pool_base;
        if (off >= FRAME_W'(TABLE_PAGES))
            return -1;
        return int'(off);
    endfunction

    function automatic void predict_page_op(input logic req_cmd,
                                            input logic [VPN_W-1:0] req_vpn,
                                            input logic [FRAME_W-1:0] req_frame,
                                            input logic [PERM_W-1:0] req_perms,
                                            output logic ok_o,
                                            output logic [FRAME_W-1:0] old_o);
        int               lvls;
        int               lvl;
        int               page;
        int               need;
        int               np;
        int               a;
        int               i;
        logic [PTE_W-1:0] e;
        logic [PTE_W-1:0] leaf;
        lvls  = five_level_walk ? 5 : 4;
        page  = 0;
        ok_o  = 1'b0;
        old_o = '0;
        if (req_cmd == CMD_MAP)
        begin
            need = 0;
            for (lvl = lvls; lvl > 1; lvl--)
            begin
                e = pt_mem[entry_addr(page, req_vpn, lvl)];
                if (e == '0)
                begin
                    need = lvl - 1;
                    break;
                end
                page = linked_page(e);
                if (page < 0)
                    return;
            end
            if (free_page + need > TABLE_PAGES)
                return;
            page = 0;
            for (lvl = lvls; lvl > 1; lvl--)
            begin
                a = entry_addr(page, req_vpn, lvl);
                e = pt_mem[a];
                if (e == '0)
                begin
                    np = free_page;
                    free_page++;
                    for (i = 0; i < ENTRIES_PER_TABLE; i++)
                        pt_mem[np * ENTRIES_PER_TABLE + i] = '0;
                    // link as present, writable, user
                    pt_mem[a] = {12'h000, pool_base + FRAME_W'(np), 12'h007};
                    page = np;
                end
                else
                    page = linked_page(e);
            end
            leaf     = {12'h000, req_frame, 12'h001};
            leaf[1]  = req_perms[PERM_WRITE];
            leaf[2]  = req_perms[PERM_USER];
            leaf[63] = !req_perms[PERM_EXEC];
            pt_mem[entry_addr(page, req_vpn, 1)] = leaf;
            ok_o = 1'b1;
        end
        else
        begin
            ok_o = 1'b1;
            for (lvl = lvls; lvl > 1; lvl--)
            begin
                e = pt_mem[entry_addr(page, req_vpn, lvl)];
                if (e == '0)
                    return;
                page = linked_page(e);
                if (page < 0)
                    return;
            end
            a = entry_addr(page, req_vpn, 1);
            old_o = pt_mem[a][PTE_FRAME_HI:PTE_FRAME_LO];
            pt_mem[a] = '0;
        end
    endfunction

    task automatic wait_for_results;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FIVE_LEVEL)
            five_level_walk = data[0];
        else
            pool_base = data[FRAME_W-1:0];
    endtask

    task automatic apply_setting(input logic five, input logic [FRAME_W-1:0] base);
        wait_for_results;
        write_register(CFG_FIVE_LEVEL, CFG_DATA_W'(five));
        write_register(CFG_TABLE_BASE, base);
    endtask

    task automatic issue_request(input logic req_cmd, input logic [VPN_W-1:0] req_vpn,
                                 input logic [FRAME_W-1:0] req_frame,
                                 input logic [PERM_W-1:0] req_perms);
        page_result_t       predicted;
        logic               p_ok;
        logic [FRAME_W-1:0] p_old;
        int                 gap;
        @(posedge clk);
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 1)
                while (busy)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= req_cmd;
        vpn   <= req_vpn;
        frame <= req_frame;
        perms <= req_perms;
        do
            @(posedge clk);
        while (busy);
        start <= 1'b0;
        predict_page_op(req_cmd, req_vpn, req_frame, req_perms, p_ok, p_old);
        predicted.ok        = p_ok;
        predicted.old_frame = p_old;
        pending_results.push_back(predicted);
        if (req_cmd == CMD_MAP && p_ok)
        begin
            known_vpns.push_back(req_vpn);
            if (known_vpns.size() > KNOWN_VPN_MAX)
                known_vpns.delete(0);
        end
    endtask

    task automatic random_traffic(input int count, input int fresh_pct);
        logic [63:0]        raw;
        logic [VPN_W-1:0]   v;
        logic [FRAME_W-1:0] fr;
        logic [PERM_W-1:0]  pm;
        int                 r;
        int                 n;
        for (n = 0; n < count; n++)
        begin
            r   = $urandom_range(0, 99);
            raw = {$urandom, $urandom};
            if (known_vpns.size() == 0 || r < fresh_pct)
                v = raw[VPN_W-1:0];
            else
            begin
                v = known_vpns[$urandom_range(0, known_vpns.size() - 1)];
                if (r < 70)
                    v[8:0] = raw[8:0];
                else if (r < 80)
                    v[17:0] = raw[17:0];
            end
            raw = {$urandom, $urandom};
            fr  = raw[FRAME_W-1:0];
            pm  = PERM_W'($urandom);
            if (idling_on && $urandom_range(0, 49) == 0)
                wait_for_results;
            issue_request(logic'($urandom_range(0, 1)), v, fr, pm);
        end
    endtask

    task automatic test_directed_walks;
        int i;
        apply_setting(1'b0, BASE_WRAP);
        issue_request(CMD_UNMAP, '0, '0, '0);
        issue_request(CMD_MAP, '0, '0, '0);
        issue_request(CMD_UNMAP, '0, '1, '1);
        issue_request(CMD_UNMAP, '0, '0, '0);
        for (i = 0; i < 8; i++)
            issue_request(CMD_MAP, VPN_W'(i), FRAME_MAX ^ FRAME_W'(i), PERM_W'(i));
        issue_request(CMD_UNMAP, 44'd7, '0, '0);
        issue_request(CMD_UNMAP, 44'd3, '0, '0);
        issue_request(CMD_MAP, '1, 40'hAA_AAAA_AAAA, 3'b111);
        issue_request(CMD_UNMAP, 44'h00F_FFFF_FFFF, '0, '0);
        issue_request(CMD_MAP, 44'd1, 40'h5, 3'b010);
        issue_request(CMD_UNMAP, 44'd1, '0, '0);
        issue_request(CMD_UNMAP, 44'h200, '0, '0);
        issue_request(CMD_MAP, 44'h4_0000, 40'h55_5555_5555, 3'b101);
        issue_request(CMD_UNMAP, 44'h4_0000, '0, '0);
    endtask

    task automatic test_four_level_traffic;
        apply_setting(1'b0, BASE_WRAP);
        random_traffic(350, 6);
    endtask

    task automatic test_five_level_traffic;
        apply_setting(1'b1, BASE_WRAP);
        random_traffic(250, 8);
    endtask

    task automatic test_pool_exhaustion;
        logic [63:0] raw;
        int          guard;
        apply_setting(1'b0, BASE_WRAP);
        guard = 0;
        while (free_page + 3 <= TABLE_PAGES && guard < 200)
        begin
            raw = {$urandom, $urandom};
            issue_request(CMD_MAP, raw[VPN_W-1:0], raw[63:24], PERM_W'($urandom));
            guard++;
        end
        repeat (4)
        begin
            raw = {$urandom, $urandom};
            issue_request(CMD_MAP, raw[VPN_W-1:0], raw[63:24], PERM_W'($urandom));
        end
    endtask

    task automatic test_broken_links;
        apply_setting(1'b0, '0);
        random_traffic(100, 10);
        apply_setting(1'b1, FRAME_MAX);
        random_traffic(100, 10);
    endtask

    task automatic test_steady_traffic;
        wait_for_results;
        idling_on = 1'b0;
        apply_setting(1'b0, BASE_WRAP);
        random_traffic(300, 5);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: ok %0d old_frame %0h",
                       ok, old_frame);
                failures++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (ok !== oldest_result.ok)
                begin
                    $error("ok: expected %0d actual %0d", oldest_result.ok, ok);
                    failures++;
                end
                if (old_frame !== oldest_result.old_frame)
                begin
                    $error("old_frame: expected %0h actual %0h",
                           oldest_result.old_frame, old_frame);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        foreach (pt_mem[i])
            pt_mem[i] = '0;
        free_page       = 1;
        five_level_walk = 1'b0;
        pool_base       = '0;
        failures        = 0;
        idle_cycles    <= 0;
        idling_on       = 1'b1;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= CMD_MAP;
        vpn       <= '0;
        frame     <= '0;
        perms     <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FIVE_LEVEL;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        test_directed_walks;
        test_four_level_traffic;
        test_five_level_traffic;
        test_pool_exhaustion;
        test_broken_links;
        test_steady_traffic;

        wait_for_results;
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ptme_pkg.sv
hdl/ptme_store.sv
hdl/ptme_alu.sv
hdl/ptme_ctrl.sv
hdl/page_table_map_unmap_engine_top.sv
sim/page_table_map_unmap_engine_top_test.sv
